// File: rtl/button_debounce_hold_fsm_defines.svh
// Assertion macros shared by the debouncer modules.
`ifndef BUTTON_DEBOUNCE_HOLD_FSM_DEFINES_SVH
`define BUTTON_DEBOUNCE_HOLD_FSM_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BDH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdh: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define BDH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdh: next-cycle check failed");

`endif

// File: rtl/bdh_pkg.sv
`timescale 1ns / 1ps

package bdh_pkg;

    localparam int BUTTON_COUNT_DEF = 2;
    localparam int LIMIT_W          = 16;
    localparam int COUNT_W          = 17;
    localparam int STATE_W          = 3;
    localparam int CFG_ADDR_W       = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [LIMIT_W-1:0] DEBOUNCE_LIMIT_RST = 16'd10;
    localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST     = 16'd1000;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_LIMIT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_LIMIT     = 1'b1;

    typedef enum logic [STATE_W-1:0] {
        PH_RELEASED  = 3'd0,
        PH_PRESSING  = 3'd1,
        PH_PRESSED   = 3'd2,
        PH_HOLD      = 3'd3,
        PH_RELEASING = 3'd4
    } t_phase;

endpackage

// File: rtl/bdh_lane.sv
`timescale 1ns / 1ps

`include "button_debounce_hold_fsm_defines.svh"

module bdh_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic                             i_level,
    input  logic [bdh_pkg::LIMIT_W-1:0]      i_debounce_limit,
    input  logic [bdh_pkg::LIMIT_W-1:0]      i_hold_limit,
    output logic [bdh_pkg::STATE_W-1:0]      o_state_next
);

    bdh_pkg::t_phase                 r_phase, n_phase;
    logic [bdh_pkg::COUNT_W-1:0]     r_deb_count, n_deb_count;
    logic [bdh_pkg::COUNT_W-1:0]     r_held_count, n_held_count;
    logic                            r_prev_level;

    logic [bdh_pkg::COUNT_W-1:0]     w_deb_inc;
    logic [bdh_pkg::COUNT_W-1:0]     w_held_inc;
    logic [bdh_pkg::COUNT_W-1:0]     w_deb_limit;
    logic [bdh_pkg::COUNT_W-1:0]     w_hold_limit;

    assign w_deb_inc  = (r_deb_count == bdh_pkg::COUNT_MAX) ? r_deb_count
                                                            : r_deb_count + 1'b1;
    assign w_held_inc = (r_held_count == bdh_pkg::COUNT_MAX) ? r_held_count
                                                             : r_held_count + 1'b1;
    assign w_deb_limit  = {1'b0, i_debounce_limit};
    assign w_hold_limit = {1'b0, i_hold_limit};

    always_comb begin
        n_phase      = r_phase;
        n_deb_count  = r_deb_count;
        n_held_count = r_held_count;
        case (r_phase)
            bdh_pkg::PH_RELEASED: begin
                if (!i_level) begin
                    n_phase = bdh_pkg::PH_PRESSING;
                end
            end
            bdh_pkg::PH_PRESSING: begin
                if (!i_level && !r_prev_level) begin
                    n_deb_count = w_deb_inc;
                    if (w_deb_inc > w_deb_limit) begin
                        n_deb_count = '0;
                        n_phase     = bdh_pkg::PH_PRESSED;
                    end
                end else begin
                    n_deb_count = '0;
                    n_phase     = bdh_pkg::PH_RELEASED;
                end
            end
            bdh_pkg::PH_PRESSED: begin
                if (!i_level && !r_prev_level) begin
                    n_held_count = w_held_inc;
                    if (w_held_inc > w_hold_limit) begin
                        n_held_count = '0;
                        n_phase      = bdh_pkg::PH_HOLD;
                    end
                end else begin
                    n_held_count = '0;
                    n_phase      = bdh_pkg::PH_RELEASING;
                end
            end
            bdh_pkg::PH_HOLD: begin
                if (i_level) begin
                    n_phase = bdh_pkg::PH_RELEASING;
                end
            end
            bdh_pkg::PH_RELEASING: begin
                if (i_level && r_prev_level) begin
                    n_deb_count = w_deb_inc;
                    if (w_deb_inc > w_deb_limit) begin
                        n_deb_count = '0;
                        n_phase     = bdh_pkg::PH_RELEASED;
                    end
                end else begin
                    n_deb_count = '0;
                    n_phase     = bdh_pkg::PH_PRESSING;
                end
            end
            default: begin
                // hold an unknown code; only the level history moves
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= bdh_pkg::PH_RELEASED;
            r_deb_count  <= '0;
            r_held_count <= '0;
            r_prev_level <= 1'b1;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_deb_count  <= n_deb_count;
            r_held_count <= n_held_count;
            r_prev_level <= i_level;
        end
    end

    assign o_state_next = n_phase;

    // debounce count is always cleared on entry to released
    `BDH_ASSERT_NOW(a_released_deb_clear, i_clk, i_rst_n, r_phase == bdh_pkg::PH_RELEASED, r_deb_count == '0)
    // hold count lives only while pressed
    `BDH_ASSERT_NOW(a_held_only_pressed, i_clk, i_rst_n, r_phase != bdh_pkg::PH_PRESSED, r_held_count == '0)

endmodule

// File: rtl/bdh_merge.sv
`timescale 1ns / 1ps

`include "button_debounce_hold_fsm_defines.svh"

module bdh_merge #(
    parameter int BUTTON_COUNT = bdh_pkg::BUTTON_COUNT_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    i_out_stall,
    input  logic [bdh_pkg::STATE_W*BUTTON_COUNT-1:0] i_lane_states,
    output logic                                    o_in_stall,
    output logic                                    o_accept,
    output logic                                    o_out_valid,
    output logic [bdh_pkg::STATE_W*BUTTON_COUNT-1:0] o_button_states
);

    localparam int DATA_W = bdh_pkg::STATE_W * BUTTON_COUNT;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_skid_valid;
    logic [DATA_W-1:0] r_skid_data;
    logic              w_accept;
    logic              w_out_free;

    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            // output is stalled: park the new item
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_lane_states;
        end
        if (!w_out_free && w_accept) begin
            r_skid_data <= i_lane_states;
        end
    end

    assign o_in_stall      = r_skid_valid;
    assign o_accept        = w_accept;
    assign o_out_valid     = r_out_valid;
    assign o_button_states = r_out_data;

    `BDH_ASSERT_NOW(a_skid_implies_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `BDH_ASSERT_NEXT(a_park_on_stall, i_clk, i_rst_n, w_accept && r_out_valid && i_out_stall, r_skid_valid)
    `BDH_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_out_stall, (r_out_data == $past(r_skid_data)) && !r_skid_valid)

endmodule

// File: rtl/button_debounce_hold_fsm.sv
`timescale 1ns / 1ps

// channel  | valid       | stall        | payload
// ---------+-------------+--------------+---------------------------
// input    | i_in_valid  | o_in_stall   | i_pin_levels (1 bit/button)
// output   | o_out_valid | i_out_stall  | o_button_states (3 bits/button)
// config   | i_cfg_wr_en | -            | i_cfg_addr, i_cfg_wr_data
//
// One item per cycle while o_in_stall is low; each result is registered on acceptance.
// Each button has its own lane with one compare and increment per item.
// A two-entry output buffer keeps input flowing for one stalled result;
// the input stalls only while both entries are full.
// Synchronous active-low reset: all buttons released, limits 10 and 1000.

module button_debounce_hold_fsm #(
    parameter int BUTTON_COUNT = bdh_pkg::BUTTON_COUNT_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic [BUTTON_COUNT-1:0]                  i_pin_levels,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic [bdh_pkg::STATE_W*BUTTON_COUNT-1:0] o_button_states,
    input  logic                                     i_cfg_wr_en,
    input  logic [bdh_pkg::CFG_ADDR_W-1:0]           i_cfg_addr,
    input  logic [bdh_pkg::LIMIT_W-1:0]              i_cfg_wr_data
);

    localparam int DATA_W = bdh_pkg::STATE_W * BUTTON_COUNT;

    logic [bdh_pkg::LIMIT_W-1:0] r_debounce_limit;
    logic [bdh_pkg::LIMIT_W-1:0] r_hold_limit;
    logic [DATA_W-1:0]           w_lane_states;
    logic                        w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit <= bdh_pkg::DEBOUNCE_LIMIT_RST;
            r_hold_limit     <= bdh_pkg::HOLD_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                bdh_pkg::CFG_DEBOUNCE_LIMIT: r_debounce_limit <= i_cfg_wr_data;
                bdh_pkg::CFG_HOLD_LIMIT:     r_hold_limit     <= i_cfg_wr_data;
                default: begin
                    r_hold_limit <= r_hold_limit;
                end
            endcase
        end
    end

    for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
        bdh_lane u_lane (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_step           (w_accept),
            .i_level          (i_pin_levels[g]),
            .i_debounce_limit (r_debounce_limit),
            .i_hold_limit     (r_hold_limit),
            .o_state_next     (w_lane_states[bdh_pkg::STATE_W*g +: bdh_pkg::STATE_W])
        );
    end

    bdh_merge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_out_stall     (i_out_stall),
        .i_lane_states   (w_lane_states),
        .o_in_stall      (o_in_stall),
        .o_accept        (w_accept),
        .o_out_valid     (o_out_valid),
        .o_button_states (o_button_states)
    );

endmodule
